@@ design/sbrc_pkg.sv @@
// shared types and constants for the substring run counter
package sbrc_pkg;

    localparam int PAT_W   = 64;   // pattern register width
    localparam int LEN_W   = 4;    // pattern length register width
    localparam int CNT_W   = 32;   // counter width
    localparam int SINCE_W = 4;    // bytes-since-match width
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 4;    // apb byte address, registers at 8*i

    localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    // result item packing, match_now in the lowest bit
    localparam int OUT_BITS = 1 + 3 * CNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // register index, taken from paddr[3]
    typedef enum logic {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } t_reg_idx;

    // per-item control from the window stage to the counter stage
    typedef struct packed {
        logic restart;
        logic window_hit;
    } t_scan;

endpackage

@@ design/substring_run_counter.sv @@
// top level: apb registers, input register, scan and count logic, result register
// the result passes through the input register and then the result register
// throughput: one item per cycle while the result sink is ready; the 8-byte window compare
//   and the 32-bit counter update are both combinational between input and result registers
// reset (synchronous, active low): pattern 0, length 1, counts and runs 0,
//   window empty, pipeline empty; no clearing pass
module substring_run_counter #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic [0:0]                    s_axis_tuser,  // [0] restart
    // result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] match_now, [32:1] total_count, [64:33] current_run,
    // [96:65] longest_run, [103:97] zero
    output logic [sbrc_pkg::OUT_W-1:0]    m_axis_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [sbrc_pkg::PAT_W-1:0]    pwdata,
    output logic [sbrc_pkg::PAT_W-1:0]    prdata,
    output logic                          pready
);
    import sbrc_pkg::*;

    // configuration registers
    logic [PAT_W-1:0] r_pattern;
    logic [LEN_W-1:0] r_length;
    logic [LEN_W-1:0] len_eff;
    t_reg_idx         reg_idx;
    logic             cfg_write;

    // input stage
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_restart;

    // result stage
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic             advance;
    t_scan            scan;
    logic             hit;
    logic [CNT_W-1:0] total, run, best;

    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= LEN_W'(1);
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PATTERN_BYTES:  r_pattern <= pwdata;
                REG_PATTERN_LENGTH: r_length  <= pwdata[LEN_W-1:0];
                default:            r_pattern <= r_pattern;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_BYTES:  prdata = r_pattern;
            REG_PATTERN_LENGTH: prdata = {{(PAT_W-LEN_W){1'b0}}, r_length};
            default:            prdata = '0;
        endcase
    end

    // zero length acts as one, anything past the window acts as the window size
    always_comb begin
        if (r_length == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_length > LEN_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = r_length;
        end
    end

    // the held item moves on when the result register is empty or drains now
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser[0];
        end
    end

    sbrc_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .i_pattern (r_pattern),
        .i_len     (len_eff),
        .o_scan    (scan)
    );

    sbrc_counters u_counters (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_scan    (scan),
        .i_len     (len_eff),
        .o_hit     (hit),
        .o_total   (total),
        .o_run     (run),
        .o_best    (best)
    );

    // result register, held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {{(OUT_W-OUT_BITS){1'b0}}, best, run, total, hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ design/sbrc_window.sv @@
// recent byte window, fill tracking and parallel pattern compare
module sbrc_window #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [sbrc_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_restart,
    input  logic [sbrc_pkg::PAT_W-1:0]   i_pattern,
    input  logic [sbrc_pkg::LEN_W-1:0]   i_len,
    output sbrc_pkg::t_scan              o_scan
);
    import sbrc_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    logic [BYTE_W-1:0] r_window [MAX_PATTERN];
    logic [BYTE_W-1:0] n_window [MAX_PATTERN];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [BYTE_W-1:0] pat_arr [8];
    logic              all_eq;
    logic [LEN_W-1:0]  pidx;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            pat_arr[b] = i_pattern[b*BYTE_W +: BYTE_W];
        end
    end

    // newest byte at index 0
    always_comb begin
        n_window[0] = i_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_window[k] = r_window[k-1];
        end
        if (i_restart) begin
            n_fill = FILL_W'(1);
        end else if (r_fill == FILL_W'(MAX_PATTERN)) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    // window[k] lines up with pattern byte len-1-k
    always_comb begin
        all_eq = 1'b1;
        pidx   = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            pidx = i_len - LEN_W'(k) - LEN_W'(1);
            if ((LEN_W'(k) < i_len) && (n_window[k] != pat_arr[pidx[2:0]])) begin
                all_eq = 1'b0;
            end
        end
    end

    assign o_scan.restart    = i_restart;
    assign o_scan.window_hit = all_eq && (LEN_W'(n_fill) >= i_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_advance) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= n_window[k];
            end
        end
    end

endmodule

@@ design/sbrc_counters.sv @@
// overlap spacing, occurrence count and run tracking
module sbrc_counters (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  sbrc_pkg::t_scan             i_scan,
    input  logic [sbrc_pkg::LEN_W-1:0]  i_len,
    output logic                        o_hit,
    output logic [sbrc_pkg::CNT_W-1:0]  o_total,
    output logic [sbrc_pkg::CNT_W-1:0]  o_run,
    output logic [sbrc_pkg::CNT_W-1:0]  o_best
);
    import sbrc_pkg::*;

    logic [SINCE_W-1:0] r_since, n_since, base_since, span;
    logic [CNT_W-1:0]   r_total, n_total, base_total;
    logic [CNT_W-1:0]   r_run, n_run, base_run;
    logic [CNT_W-1:0]   r_best, n_best, base_best;
    logic               far_enough;
    logic               hit;

    always_comb begin
        // restart clears the state before this byte counts
        base_since = i_scan.restart ? SINCE_MAX : r_since;
        base_total = i_scan.restart ? '0 : r_total;
        base_run   = i_scan.restart ? '0 : r_run;
        base_best  = i_scan.restart ? '0 : r_best;

        span       = (base_since == SINCE_MAX) ? SINCE_MAX : base_since + SINCE_W'(1);
        far_enough = (span >= i_len);
        hit        = far_enough && i_scan.window_hit;

        n_total = base_total;
        n_run   = base_run;
        n_best  = base_best;
        n_since = span;
        if (hit) begin
            n_since = '0;
            n_total = (base_total == CNT_MAX) ? base_total : base_total + CNT_W'(1);
            // back-to-back only when exactly one pattern length apart
            if ((span == i_len) && (base_run != '0)) begin
                n_run = (base_run == CNT_MAX) ? base_run : base_run + CNT_W'(1);
            end else begin
                n_run = CNT_W'(1);
            end
            if (n_run > base_best) begin
                n_best = n_run;
            end
        end else if (far_enough) begin
            // gap or mismatch ends the run
            n_run = '0;
        end
    end

    assign o_hit   = hit;
    assign o_total = n_total;
    assign o_run   = n_run;
    assign o_best  = n_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since <= SINCE_MAX;
            r_total <= '0;
            r_run   <= '0;
            r_best  <= '0;
        end else if (i_advance) begin
            r_since <= n_since;
            r_total <= n_total;
            r_run   <= n_run;
            r_best  <= n_best;
        end
    end

endmodule

@@ sim/substring_run_counter_checker.sv @@
// scoreboard for the substring run counter: predicts each result item and compares it
module substring_run_counter_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [7:0]                  i_in_data,   // [7:0] data_byte
    input  logic [0:0]                  i_in_user,   // [0] restart
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    // [0] match_now, [32:1] total_count, [64:33] current_run, [96:65] longest_run
    input  logic [sbrc_pkg::OUT_W-1:0]  i_out_data,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [sbrc_pkg::ADDR_W-1:0] i_paddr,
    input  logic [sbrc_pkg::PAT_W-1:0]  i_pwdata,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_hits
);
    import sbrc_pkg::*;

    localparam int WIN_D = 8;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] total;
        logic [CNT_W-1:0] run;
        logic [CNT_W-1:0] best;
    } t_counts;

    // register copies
    logic [PAT_W-1:0]   pat_reg  = '0;
    logic [LEN_W-1:0]   plen_reg = LEN_W'(1);

    // scan state
    logic [BYTE_W-1:0]  win [WIN_D];
    logic [LEN_W-1:0]   fill;
    logic [SINCE_W-1:0] since;
    logic [CNT_W-1:0]   total_q;
    logic [CNT_W-1:0]   run_q;
    logic [CNT_W-1:0]   best_q;

    t_counts due_counts [$];
    int err_cnt = 0;
    int hit_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_pending = due_counts.size();
    assign o_hits    = hit_cnt;

    function automatic void clear_scan();
        for (int i = 0; i < WIN_D; i++) win[i] = '0;
        fill    = '0;
        since   = SINCE_MAX;
        total_q = '0;
        run_q   = '0;
        best_q  = '0;
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // advance the scan by one byte and return the counts after the update
    function automatic t_counts scan_byte(input logic [7:0] b, input logic rs);
        int      len;
        int      span;
        logic    hit;
        t_counts r;
        len = (plen_reg == 0) ? 1 : ((int'(plen_reg) > WIN_D) ? WIN_D : int'(plen_reg));
        if (rs)
            clear_scan();
        for (int i = WIN_D - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (int'(fill) < WIN_D)
            fill = fill + 1'b1;
        span = int'(since) + 1;
        if (span > int'(SINCE_MAX))
            span = int'(SINCE_MAX);
        // newest byte lines up with the last pattern byte
        hit = (span >= len) && (int'(fill) >= len);
        for (int k = 0; k < len; k++)
            if (win[k] != pat_reg[8*(len-1-k) +: 8])
                hit = 1'b0;
        if (hit) begin
            total_q = bump(total_q);
            if (span == len && run_q != 0)
                run_q = bump(run_q);
            else
                run_q = CNT_W'(1);
            if (run_q > best_q)
                best_q = run_q;
            since = '0;
        end else begin
            if (span >= len)
                run_q = '0;
            since = SINCE_W'(span);
        end
        r.hit   = hit;
        r.total = total_q;
        r.run   = run_q;
        r.best  = best_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_counts want;
        if (!i_rst_n) begin
            clear_scan();
            pat_reg  = '0;
            plen_reg = LEN_W'(1);
            due_counts.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3]))
                    REG_PATTERN_BYTES:  pat_reg  = i_pwdata;
                    REG_PATTERN_LENGTH: plen_reg = i_pwdata[LEN_W-1:0];
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                want = scan_byte(i_in_data, i_in_user[0]);
                due_counts.push_back(want);
                if (want.hit)
                    hit_cnt++;
            end
            if (i_out_valid && i_out_ready) begin
                if (due_counts.size() == 0) begin
                    $display("%0t: result item with none expected, got %h", $time, i_out_data);
                    err_cnt++;
                end else begin
                    want = due_counts.pop_front();
                    check_field("match_now", CNT_W'(want.hit), CNT_W'(i_out_data[0]));
                    check_field("total_count", want.total, i_out_data[CNT_W:1]);
                    check_field("current_run", want.run, i_out_data[2*CNT_W:CNT_W+1]);
                    check_field("longest_run", want.best, i_out_data[3*CNT_W:2*CNT_W+1]);
                    check_field("padding", '0, CNT_W'(i_out_data[OUT_W-1:OUT_BITS]));
                end
            end
        end
    end

endmodule

@@ sim/substring_run_counter_test.sv @@
// testbench top for the substring run counter: clock, reset, stimulus and verdict
module substring_run_counter_test;
    import sbrc_pkg::*;

    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 65;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = '0;    // [7:0] data_byte
    logic [0:0]          s_axis_tuser  = '0;    // [0] restart
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;          // [0] match, [32:1] total, [64:33] run, [96:65] best
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [ADDR_W-1:0]   paddr         = '0;
    logic [PAT_W-1:0]    pwdata        = '0;
    logic [PAT_W-1:0]    prdata;
    logic                pready;

    int   bytes_sent    = 0;     // counted by the sender as items are accepted
    int   results_seen  = 0;     // counted at the result handshake
    int   settings_used = 0;
    int   err_cnt;
    int   pend_cnt;
    int   hit_cnt;
    bit   hold_req      = 1'b0;  // asks the receiver for one long hold-off
    bit   burst_mode    = 1'b0;  // sender offers items back to back
    bit   restart_next  = 1'b0;  // flag the next byte as a stream start
    logic [31:0] alpha  = '0;    // four symbols the random stream draws from

    substring_run_counter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    substring_run_counter_checker scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (err_cnt),
        .o_pending   (pend_cnt),
        .o_hits      (hit_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        #5_000_000;
        $display("substring_run_counter_test: done, errors");
        $finish;
    end

    // result counter, nonblocking so readers after the edge see the old value
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            results_seen <= results_seen + 1;
    end

    // receiver: random stalls, mostly short, now and then one long hold-off on request
    initial begin : result_sink
        int r;
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                n = 0;
                while (n < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    n++;
                end
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_axis_tready <= 1'b1;
                    n = $urandom_range(1, 20);
                end else if (r < 92) begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    m_axis_tready <= 1'b0;
                    n = $urandom_range(8, 40);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // sender gap length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_sym();
        int s;
        s = $urandom_range(0, 3);
        return alpha[8*s +: 8];
    endfunction

    // offer one item and hold it until accepted; tvalid stays high on return
    task automatic push_byte(input logic [7:0] b, input logic rs);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= rs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // one byte of stream, carrying a pending restart, then maybe an idle gap
    task automatic send(input logic [7:0] b);
        int n;
        push_byte(b, restart_next);
        restart_next = 1'b0;
        n = burst_mode ? 0 : gap_len();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every accepted item has its result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != bytes_sent) @(posedge i_clk);
    endtask

    // apb write: setup cycle, access cycle, then the bus returns to idle
    task automatic reg_write(input t_reg_idx idx, input logic [PAT_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // registers change only with the block idle
    task automatic set_pattern(input logic [PAT_W-1:0] pat, input logic [3:0] len);
        drain();
        reg_write(REG_PATTERN_BYTES, pat);
        reg_write(REG_PATTERN_LENGTH, PAT_W'(len));
        settings_used++;
    endtask

    // random stream built mostly from whole and partial copies of the pattern
    task automatic run_phase(input logic [PAT_W-1:0] pat, input int len, input int n_items,
                             input bit pause_mid);
        int  target;
        int  r;
        int  j;
        int  k;
        bit  paused;
        target = bytes_sent + n_items;
        paused = 1'b0;
        while (bytes_sent < target) begin
            // sender waits for the pipeline to empty once in the middle
            if (pause_mid && !paused && bytes_sent >= target - n_items / 2) begin
                drain();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 40) begin
                // back-to-back copies form a run
                k = $urandom_range(1, 4);
                repeat (k)
                    for (int i = 0; i < len; i++) send(pat[8*i +: 8]);
            end else if (r < 55) begin
                // broken attempt: a prefix then a symbol
                j = $urandom_range(0, len - 1);
                for (int i = 0; i < j; i++) send(pat[8*i +: 8]);
                send(pick_sym());
            end else if (r < 70) begin
                repeat ($urandom_range(1, 6)) send(pick_sym());
            end else if (r < 80) begin
                // noise over the full byte range
                repeat ($urandom_range(1, 4)) send(8'($urandom_range(0, 255)));
            end else if (r < 94) begin
                // a prefix right before a full copy, so candidates overlap
                j = $urandom_range(1, len);
                for (int i = 0; i < j; i++) send(pat[8*i +: 8]);
                for (int i = 0; i < len; i++) send(pat[8*i +: 8]);
            end else begin
                restart_next = 1'b1;
            end
        end
    endtask

    initial begin : stimulus
        logic [PAT_W-1:0] pat;
        logic [3:0]       raw_len;
        int               eff;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults after reset: pattern of one zero byte
        send(8'h00);
        send(8'hFF);
        send(8'h00);
        send(8'h00);

        // length zero acts as one, upper pattern bytes ignored
        set_pattern(64'hA5C3_0F96_1234_56EE, 4'd0);
        send(8'hEE);
        send(8'hEE);

        // length above the maximum acts as eight, all-ones pattern, restart first
        set_pattern('1, 4'd15);
        restart_next = 1'b1;
        repeat (8) send(8'hFF);

        // overlapping candidates are skipped, a gap byte ends the run
        set_pattern(64'h7788_99AA_BBCC_5A5A, 4'd2);
        repeat (5) send(8'h5A);
        send(8'h00);
        send(8'h5A);
        send(8'h5A);

        // restart on the last byte: stream too short for a match
        set_pattern(64'hFFFF_FFFF_FF03_0201, 4'd3);
        send(8'h01);
        send(8'h02);
        restart_next = 1'b1;
        send(8'h03);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       raw_len = 4'd1;
                1:       raw_len = 4'd8;
                2:       raw_len = 4'd0;
                3:       raw_len = 4'd15;
                default: raw_len = 4'($urandom_range(2, 12));
            endcase
            eff = (raw_len == 0) ? 1 : ((raw_len > 8) ? 8 : int'(raw_len));
            alpha = $urandom;
            if (p == 1)
                alpha = '1;                     // all-ones pattern
            else if (p == 4)
                alpha = {4{alpha[7:0]}};        // one symbol, heavy overlap
            else if (p == 6)
                alpha[15:0] = '0;               // zero bytes, same as an empty window
            for (int i = 0; i < 8; i++)
                pat[8*i +: 8] = (i < eff) ? pick_sym() : 8'($urandom_range(0, 255));
            set_pattern(pat, raw_len);
            burst_mode = (p % 4 == 3) || (p == 0);
            // receiver stalls for a long stretch while the sender keeps offering
            if (p == 3)
                hold_req = 1'b1;
            run_phase(pat, eff, PHASE_ITEMS, p == 7);
        end

        burst_mode = 1'b0;
        drain();
        repeat (10) @(posedge i_clk);

        if (pend_cnt != 0)
            $display("%0t: %0d expected result items never arrived", $time, pend_cnt);
        $display("covered %0d bytes under %0d pattern settings, %0d occurrences predicted",
                 bytes_sent, settings_used, hit_cnt);
        $display("with random stalls on both streams and one long receiver hold-off");
        if (err_cnt == 0 && pend_cnt == 0)
            $display("substring_run_counter_test: done, clean");
        else
            $display("substring_run_counter_test: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
design/sbrc_pkg.sv
design/sbrc_window.sv
design/sbrc_counters.sv
design/substring_run_counter.sv
sim/substring_run_counter_checker.sv
sim/substring_run_counter_test.sv
